// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the list engine RTL.
// Needs signals named clk and rst_n in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define PLE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ple_pkg.sv -----
// Package for the positional list engine: sizes, command and status codes,
// and the transaction and controller/datapath struct types. No dependencies.
package ple_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = 7;
  localparam int VAL_W    = 32;

  localparam logic [2:0] CMD_INS_FRONT = 3'd0;
  localparam logic [2:0] CMD_INS_BACK  = 3'd1;
  localparam logic [2:0] CMD_INS_POS   = 3'd2;
  localparam logic [2:0] CMD_DEL_FRONT = 3'd3;
  localparam logic [2:0] CMD_DEL_BACK  = 3'd4;
  localparam logic [2:0] CMD_DEL_POS   = 3'd5;
  localparam logic [2:0] CMD_LIST      = 3'd6;
  localparam logic [2:0] CMD_COUNT     = 3'd7;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_INVALID = 2'd1;
  localparam logic [1:0] STAT_EMPTY   = 2'd2;
  localparam logic [1:0] STAT_FULL    = 2'd3;

  // Datapath operations on the cell row.
  localparam logic [1:0] DP_HOLD   = 2'd0;
  localparam logic [1:0] DP_INSERT = 2'd1;
  localparam logic [1:0] DP_DELETE = 2'd2;
  localparam logic [1:0] DP_ROTATE = 2'd3;

  typedef struct packed {
    logic [2:0]              command;
    logic signed [VAL_W-1:0] value;
    logic [6:0]              position;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] element;
    logic                    element_valid;
    logic [CNT_W-1:0]        count;
    logic                    last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]              op;
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] value;
  } dp_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0]        held;
    logic signed [VAL_W-1:0] head;
  } dp_stat_t;

endpackage

// ----- rtl/ple_datapath.sv -----
// Datapath of the list engine: a row of value cells and the element count.
// Depends on ple_pkg; driven by ple_ctrl through dp_cmd_t.
module ple_datapath
  import ple_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  dp_cmd_t  dp_cmd,
  output dp_stat_t dp_stat
);

  logic signed [VAL_W-1:0] cell_r   [CAPACITY];
  logic signed [VAL_W-1:0] cell_nxt [CAPACITY];
  logic signed [VAL_W-1:0] prev_w   [CAPACITY];
  logic signed [VAL_W-1:0] next_w   [CAPACITY];
  logic [CNT_W-1:0]        held_r;
  logic [CNT_W-1:0]        held_nxt;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign prev_w[g] = cell_r[g];
    end else begin : g_mid
      assign prev_w[g] = cell_r[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign next_w[g] = cell_r[g];
    end else begin : g_body
      assign next_w[g] = cell_r[g+1];
    end

    always_comb begin
      cell_nxt[g] = cell_r[g];
      unique case (dp_cmd.op)
        DP_INSERT: begin
          if (IDX_W'(g) == dp_cmd.idx) begin
            cell_nxt[g] = dp_cmd.value;
          end else if (IDX_W'(g) > dp_cmd.idx && CNT_W'(g) <= held_r) begin
            cell_nxt[g] = prev_w[g];
          end
        end
        DP_DELETE: begin
          if (IDX_W'(g) >= dp_cmd.idx && CNT_W'(g + 1) < held_r) begin
            cell_nxt[g] = next_w[g];
          end
        end
        DP_ROTATE: begin
          // The head wraps to the tail so a full listing restores the order.
          if (CNT_W'(g + 1) < held_r) begin
            cell_nxt[g] = next_w[g];
          end else if (CNT_W'(g + 1) == held_r) begin
            cell_nxt[g] = cell_r[0];
          end
        end
        DP_HOLD: begin
          cell_nxt[g] = cell_r[g];
        end
      endcase
    end
  end

  always_comb begin
    unique case (dp_cmd.op)
      DP_INSERT: held_nxt = held_r + CNT_W'(1);
      DP_DELETE: held_nxt = held_r - CNT_W'(1);
      DP_ROTATE: held_nxt = held_r;
      DP_HOLD:   held_nxt = held_r;
    endcase
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else begin
      held_r <= held_nxt;
    end
  end

  assign dp_stat.held = held_r;
  assign dp_stat.head = cell_r[0];

endmodule

// ----- rtl/ple_ctrl.sv -----
// Controller of the list engine: command decode, range checks, listing
// sequencer and the result register. Depends on ple_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ple_ctrl
  import ple_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_result,
  output dp_cmd_t   dp_cmd,
  input  dp_stat_t  dp_stat
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LIST = 1'b1;

  logic             state_r, state_nxt;
  logic [IDX_W-1:0] list_idx_r, list_idx_nxt;
  logic             out_strobe_r, out_strobe_nxt;
  out_item_t        out_r, out_nxt;

  logic [CNT_W-1:0] held;
  logic [CNT_W-1:0] ins_pos, del_pos, edit_pos_m1;
  logic             full, empty, ins_ok, del_ok, list_last;

  assign held  = dp_stat.held;
  assign full  = (held >= CNT_W'(CAPACITY));
  assign empty = (held == '0);
  assign busy  = (state_r == S_LIST);

  always_comb begin
    unique case (in_item.command)
      CMD_INS_FRONT: ins_pos = CNT_W'(1);
      CMD_INS_BACK:  ins_pos = held + CNT_W'(1);
      default:       ins_pos = in_item.position;
    endcase
    unique case (in_item.command)
      CMD_DEL_FRONT: del_pos = CNT_W'(1);
      CMD_DEL_BACK:  del_pos = held;
      default:       del_pos = in_item.position;
    endcase
  end

  assign ins_ok = (ins_pos != '0) && (ins_pos <= held + CNT_W'(1));
  assign del_ok = (del_pos != '0) && (del_pos <= held);
  assign list_last = ({1'b0, list_idx_r} + CNT_W'(1) == held);

  always_comb begin
    state_nxt      = state_r;
    list_idx_nxt   = list_idx_r;
    out_strobe_nxt = 1'b0;
    out_nxt        = out_r;
    dp_cmd.op      = DP_HOLD;
    dp_cmd.value   = in_item.value;
    edit_pos_m1    = '0;

    out_nxt.element       = '0;
    out_nxt.element_valid = 1'b0;
    out_nxt.last          = 1'b1;
    out_nxt.count         = held;
    out_nxt.status        = STAT_OK;

    unique case (state_r)
      S_LIST: begin
        // Emit the head and rotate the row by one cell each cycle.
        dp_cmd.op             = DP_ROTATE;
        out_strobe_nxt        = 1'b1;
        out_nxt.element       = dp_stat.head;
        out_nxt.element_valid = 1'b1;
        out_nxt.last          = list_last;
        list_idx_nxt          = list_idx_r + IDX_W'(1);
        if (list_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          out_strobe_nxt = 1'b1;
          unique case (in_item.command)
            CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_POS: begin
              edit_pos_m1 = ins_pos - CNT_W'(1);
              if (full) begin
                out_nxt.status = STAT_FULL;
              end else if (!ins_ok) begin
                out_nxt.status = STAT_INVALID;
              end else begin
                dp_cmd.op     = DP_INSERT;
                out_nxt.count = held + CNT_W'(1);
              end
            end
            CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_POS: begin
              edit_pos_m1 = del_pos - CNT_W'(1);
              if (empty) begin
                out_nxt.status = STAT_EMPTY;
              end else if (!del_ok) begin
                out_nxt.status = STAT_INVALID;
              end else begin
                dp_cmd.op     = DP_DELETE;
                out_nxt.count = held - CNT_W'(1);
              end
            end
            CMD_LIST: begin
              if (empty) begin
                out_nxt.status = STAT_EMPTY;
              end else begin
                out_strobe_nxt = 1'b0;
                state_nxt      = S_LIST;
                list_idx_nxt   = '0;
              end
            end
            CMD_COUNT: begin
              out_nxt.status = STAT_OK;
            end
          endcase
        end
      end
    endcase
    dp_cmd.idx = edit_pos_m1[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      list_idx_r   <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      list_idx_r   <= list_idx_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_result = out_r;

  `PLE_ASSERT(a_held_in_range, held <= CNT_W'(CAPACITY), "element count above capacity")
  `PLE_ASSERT(a_list_nonempty, (state_r != S_LIST) || (held != '0), "listing an empty list")
  `PLE_ASSERT_NEXT(a_list_emits, state_r == S_LIST, out_strobe_r, "listing cycle gave no result")
  `PLE_ASSERT(a_elem_ok, !(out_strobe_r && out_r.element_valid) || (out_r.status == STAT_OK),
    "element result without ok status")
  `PLE_ASSERT(a_idle_single, !(out_strobe_r && !out_r.element_valid) || out_r.last,
    "single result not flagged last")

endmodule

// ----- rtl/positional_list_engine_core.sv -----
// Positional list engine: an ordered list of up to CAPACITY signed 32-bit values.
// Edit and count commands never raise busy, and the single result is strobed
// in the cycle after the command is taken. A list command on n held elements
// keeps busy high while listing and strobes one element per cycle, front to
// back, the last flagged; the cell row rotates by one place per element.
// Results cannot be held off: out_strobe is high for exactly one cycle per
// result and the receiver must take it then.
// Depends on ple_pkg, ple_ctrl and ple_datapath.
module positional_list_engine_core
  import ple_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_result
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  ple_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_result (out_result),
    .dp_cmd     (dp_cmd),
    .dp_stat    (dp_stat)
  );

  ple_datapath u_datapath (
    .clk     (clk),
    .rst_n   (rst_n),
    .dp_cmd  (dp_cmd),
    .dp_stat (dp_stat)
  );

endmodule

// ----- tb/ple_list_monitor.sv -----
`timescale 1ns / 1ps
// Checker for the positional list engine: watches both channels, keeps a shadow
// copy of the list and compares every strobed reply. Depends on ple_pkg.
module ple_list_monitor
  import ple_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  in_item,
  input  logic      out_strobe,
  input  out_item_t out_result,
  output int        mismatch_count,
  output int        replies_checked,
  output int        list_elements,
  output int        full_refusals,
  output int        replies_pending
);

  logic signed [VAL_W-1:0] shadow_cells [CAPACITY];
  int                      shadow_held;
  out_item_t               replies_due [$];
  out_item_t               oldest;

  function automatic logic [1:0] shadow_insert(int pos, logic signed [VAL_W-1:0] val);
    // The full check comes before the position check.
    if (shadow_held >= CAPACITY) return STAT_FULL;
    if (pos < 1 || pos > shadow_held + 1) return STAT_INVALID;
    for (int i = shadow_held; i > pos - 1; i--) shadow_cells[i] = shadow_cells[i - 1];
    shadow_cells[pos - 1] = val;
    shadow_held++;
    return STAT_OK;
  endfunction

  function automatic logic [1:0] shadow_delete(int pos);
    if (shadow_held == 0) return STAT_EMPTY;
    if (pos < 1 || pos > shadow_held) return STAT_INVALID;
    for (int i = pos - 1; i + 1 < shadow_held; i++) shadow_cells[i] = shadow_cells[i + 1];
    shadow_held--;
    return STAT_OK;
  endfunction

  task automatic apply_list_command(input in_item_t cmd);
    out_item_t  reply;
    logic [1:0] st;
    st = STAT_OK;
    case (cmd.command)
      CMD_INS_FRONT: st = shadow_insert(1, cmd.value);
      CMD_INS_BACK:  st = shadow_insert(shadow_held + 1, cmd.value);
      CMD_INS_POS:   st = shadow_insert(int'(cmd.position), cmd.value);
      CMD_DEL_FRONT: st = shadow_delete(1);
      CMD_DEL_BACK:  st = shadow_delete(shadow_held);
      CMD_DEL_POS:   st = shadow_delete(int'(cmd.position));
      default: ;
    endcase
    if (st == STAT_FULL) full_refusals++;
    if (cmd.command == CMD_LIST && shadow_held != 0) begin
      for (int i = 0; i < shadow_held; i++) begin
        reply = '{status: STAT_OK, element: shadow_cells[i], element_valid: 1'b1,
                  count: CNT_W'(shadow_held), last: (i == shadow_held - 1)};
        replies_due.push_back(reply);
      end
    end else begin
      reply = '{status: (cmd.command == CMD_LIST) ? STAT_EMPTY : st, element: '0,
                element_valid: 1'b0, count: CNT_W'(shadow_held), last: 1'b1};
      replies_due.push_back(reply);
    end
  endtask

  task automatic compare_field(input string name, input logic signed [32:0] want_v,
                               input logic signed [32:0] got_v);
    if (want_v !== got_v) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_held = 0;
      replies_due.delete();
      mismatch_count = 0;
      replies_checked = 0;
      list_elements = 0;
      full_refusals = 0;
      replies_pending = 0;
    end else begin
      // Replies are retired before a new transaction is predicted at the same edge.
      if (out_strobe) begin
        if (replies_due.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected reply, expected none, actual %p", $time, out_result);
        end else begin
          oldest = replies_due.pop_front();
          compare_field("status", oldest.status, out_result.status);
          compare_field("element", oldest.element, out_result.element);
          compare_field("element_valid", oldest.element_valid, out_result.element_valid);
          compare_field("count", oldest.count, out_result.count);
          compare_field("last", oldest.last, out_result.last);
          replies_checked++;
          if (oldest.element_valid) list_elements++;
        end
      end
      if (start && !busy) apply_list_command(in_item);
      replies_pending = replies_due.size();
    end
  end

endmodule

// ----- tb/tb_positional_list_engine_core.sv -----
`timescale 1ns / 1ps
// Top of the positional list engine testbench: clock, reset, directed and
// random commands, and the verdict. Depends on ple_pkg and ple_list_monitor.
module tb_positional_list_engine_core;
  import ple_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 146;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_strobe;
  out_item_t out_result;

  int mismatch_count;
  int replies_checked;
  int list_elements;
  int full_refusals;
  int replies_pending;
  int sent_count = 0;
  int cycle_count = 0;
  bit gaps_enabled = 1'b1;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  positional_list_engine_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_result(out_result)
  );

  ple_list_monitor monitor (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_item        (in_item),
    .out_strobe     (out_strobe),
    .out_result     (out_result),
    .mismatch_count (mismatch_count),
    .replies_checked(replies_checked),
    .list_elements  (list_elements),
    .full_refusals  (full_refusals),
    .replies_pending(replies_pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Holds start high until the transaction is taken at an edge with busy low.
  task automatic issue_command(input logic [2:0] op, input logic [31:0] val,
                               input logic [6:0] pos);
    int gap;
    if (gaps_enabled && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      start <= 1'b0;
      in_item <= '{command: 3'($urandom), value: $urandom, position: 7'($urandom)};
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= '{command: op, value: val, position: pos};
    do @(posedge clk); while (busy);
    sent_count++;
  endtask

  // Growing mode leans on inserts to reach a full list; otherwise deletes dominate.
  task automatic random_command(input bit growing);
    int         r;
    logic [2:0] op;
    logic [6:0] pos;
    r = $urandom_range(0, 99);
    if (growing) begin
      if (r < 38) op = CMD_INS_FRONT;
      else if (r < 73) op = CMD_INS_BACK;
      else if (r < 88) op = CMD_INS_POS;
      else if (r < 91) op = CMD_DEL_FRONT;
      else if (r < 93) op = CMD_DEL_BACK;
      else if (r < 95) op = CMD_DEL_POS;
      else if (r < 97) op = CMD_LIST;
      else op = CMD_COUNT;
    end else begin
      if (r < 25) op = CMD_DEL_FRONT;
      else if (r < 50) op = CMD_DEL_BACK;
      else if (r < 72) op = CMD_DEL_POS;
      else if (r < 78) op = CMD_INS_FRONT;
      else if (r < 82) op = CMD_INS_BACK;
      else if (r < 86) op = CMD_INS_POS;
      else if (r < 93) op = CMD_LIST;
      else op = CMD_COUNT;
    end
    if ($urandom_range(0, 9) == 0) pos = 7'($urandom_range(0, 127));
    else pos = 7'($urandom_range(0, 66));
    issue_command(op, $urandom, pos);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Empty list: every delete and the listing must report empty.
    issue_command(CMD_LIST, 32'd0, 7'd0);
    issue_command(CMD_COUNT, 32'd0, 7'd0);
    issue_command(CMD_DEL_FRONT, 32'd0, 7'd0);
    issue_command(CMD_DEL_BACK, 32'd0, 7'd0);
    issue_command(CMD_DEL_POS, 32'd0, 7'd0);
    issue_command(CMD_INS_POS, 32'h1234_5678, 7'd0);
    issue_command(CMD_INS_POS, 32'h1234_5678, 7'd2);
    issue_command(CMD_INS_POS, 32'h8000_0000, 7'd1);
    // Removing the only element leaves the list empty again.
    issue_command(CMD_DEL_POS, 32'd0, 7'd1);
    issue_command(CMD_LIST, 32'd0, 7'd0);
    issue_command(CMD_INS_FRONT, 32'h7fff_ffff, 7'd0);
    issue_command(CMD_INS_BACK, 32'h8000_0000, 7'd0);
    issue_command(CMD_INS_BACK, 32'hffff_ffff, 7'd0);
    issue_command(CMD_INS_POS, 32'h0000_0000, 7'd2);
    issue_command(CMD_INS_POS, 32'h5555_5555, 7'd5);
    issue_command(CMD_INS_POS, 32'haaaa_aaaa, 7'd127);
    issue_command(CMD_LIST, 32'd0, 7'd0);
    issue_command(CMD_DEL_POS, 32'd0, 7'd0);
    issue_command(CMD_DEL_POS, 32'd0, 7'd6);
    issue_command(CMD_DEL_POS, 32'd0, 7'd3);
    issue_command(CMD_DEL_FRONT, 32'd0, 7'd0);
    issue_command(CMD_DEL_BACK, 32'd0, 7'd0);
    issue_command(CMD_COUNT, 32'd0, 7'd0);
    issue_command(CMD_LIST, 32'd0, 7'd0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n >= RANDOM_ITEMS - 40) gaps_enabled = 1'b0;
      random_command(n < 100);
    end
    start <= 1'b0;

    @(negedge clk);
    while (replies_pending != 0) @(negedge clk);
    repeat (4) @(posedge clk);

    $display("Sent %0d commands; checked %0d replies, %0d of them listed elements.",
             sent_count, replies_checked, list_elements);
    $display("Inserts refused on a full list: %0d.", full_refusals);
    if (mismatch_count == 0 && replies_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
